FILE: rtl/eipl_pkg.sv
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
`timescale 1ns / 1ps
package eipl_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam logic [15:0] IPV4_ETHER_TYPE = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] TCP_FLAG_BITS = 8'h03;
    localparam logic [3:0] IHL_MASK = 4'hF;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] ST_NOT_IPV4 = 3'd0;
    localparam logic [2:0] ST_FRAGMENTED = 3'd1;
    localparam logic [2:0] ST_NOT_L4 = 3'd2;
    localparam logic [2:0] ST_FILTERED = 3'd3;
    localparam logic [2:0] ST_TCP = 3'd4;
    localparam logic [2:0] ST_UDP = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    typedef struct packed {
        logic [47:0] destination_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
        logic [15:0] ip_total_length;
        logic [12:0] fragment_offset;
        logic [7:0]  time_to_live;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [31:0] destination_ip;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] transport_detail;
        logic        len_ok_22;
        logic        len_ok_24;
        logic        len_ok_30;
        logic        len_ok_eth;
        logic        len_ok_l4;
    } frame_capture_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] destination_mac;
        logic [47:0] source_mac;
        logic [15:0] ether_type;
        logic [15:0] ip_total_length;
        logic [7:0]  time_to_live;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [31:0] destination_ip;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] transport_detail;
    } frame_summary_t;

endpackage

FILE: rtl/eipl_capture.sv
// Front end: counts bytes of each frame, captures header fields and flags length checks.
`timescale 1ns / 1ps
module eipl_capture #(
    parameter int MAX_FRAME_BYTES = eipl_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               in_byte,
    input  logic                     in_last,
    output logic                     cap_valid,
    input  logic                     cap_ready,
    output eipl_pkg::frame_capture_t cap_data
);
    import eipl_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    logic [PW-1:0]  pos_reg;
    logic [3:0]     ihl_reg;
    frame_capture_t cur_reg, cur_next;
    logic [PW-1:0]  pos_next;
    logic [PW-1:0]  l4;
    logic [PW-1:0]  rel;
    logic [3:0]     ihl_next;
    logic [3:0]     w;
    logic           take;

    assign in_ready = cap_ready;
    assign take = in_valid && in_ready;

    always_comb begin
        w = ihl_reg & IHL_MASK;
        if (w < 4'd5) begin
            w = 4'd5;
        end
        l4 = PW'(14) + PW'({w, 2'b00});
        rel = pos_reg - l4;
    end

    always_comb begin
        cur_next = cur_reg;
        ihl_next = ihl_reg;
        pos_next = pos_reg;
        if (pos_reg < PW'(MAX_FRAME_BYTES)) begin
            pos_next = pos_reg + PW'(1);
            if (pos_reg < PW'(6)) begin
                cur_next.destination_mac = {cur_reg.destination_mac[39:0], in_byte};
            end else if (pos_reg < PW'(12)) begin
                cur_next.source_mac = {cur_reg.source_mac[39:0], in_byte};
            end else if (pos_reg < PW'(14)) begin
                cur_next.ether_type = {cur_reg.ether_type[7:0], in_byte};
            end else if (pos_reg == PW'(14)) begin
                ihl_next = in_byte[3:0];
            end else if (pos_reg == PW'(16) || pos_reg == PW'(17)) begin
                cur_next.ip_total_length = {cur_reg.ip_total_length[7:0], in_byte};
            end else if (pos_reg == PW'(20) || pos_reg == PW'(21)) begin
                cur_next.fragment_offset = {cur_reg.fragment_offset[4:0], in_byte};
            end else if (pos_reg == PW'(22)) begin
                cur_next.time_to_live = in_byte;
            end else if (pos_reg == PW'(23)) begin
                cur_next.ip_protocol = in_byte;
            end else if (pos_reg >= PW'(26) && pos_reg < PW'(30)) begin
                cur_next.source_ip = {cur_reg.source_ip[23:0], in_byte};
            end else if (pos_reg >= PW'(30) && pos_reg < PW'(34)) begin
                cur_next.destination_ip = {cur_reg.destination_ip[23:0], in_byte};
            end
            if (pos_reg >= l4) begin
                if (rel < PW'(2)) begin
                    cur_next.source_port = {cur_reg.source_port[7:0], in_byte};
                end else if (rel < PW'(4)) begin
                    cur_next.destination_port = {cur_reg.destination_port[7:0], in_byte};
                end else if (cur_reg.ip_protocol == PROTO_UDP && rel < PW'(6)) begin
                    cur_next.transport_detail = {cur_reg.transport_detail[7:0], in_byte};
                end else if (cur_reg.ip_protocol == PROTO_TCP && rel == PW'(13)) begin
                    cur_next.transport_detail = {8'd0, in_byte & TCP_FLAG_BITS};
                end
            end
        end
        cur_next.len_ok_eth = pos_next >= PW'(14);
        cur_next.len_ok_22 = pos_next >= PW'(22);
        cur_next.len_ok_24 = pos_next >= PW'(24);
        cur_next.len_ok_30 = pos_next >= PW'(30);
        if (cur_next.ip_protocol == PROTO_TCP) begin
            cur_next.len_ok_l4 = pos_next >= l4 + PW'(14);
        end else begin
            cur_next.len_ok_l4 = pos_next >= l4 + PW'(6);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ihl_reg <= '0;
            cur_reg <= '0;
            cap_valid <= 1'b0;
        end else begin
            if (cap_ready) begin
                cap_valid <= 1'b0;
            end
            if (take) begin
                if (in_last) begin
                    cap_data <= cur_next;
                    cap_valid <= 1'b1;
                    pos_reg <= '0;
                    ihl_reg <= '0;
                    cur_reg <= '0;
                end else begin
                    pos_reg <= pos_next;
                    ihl_reg <= ihl_next;
                    cur_reg <= cur_next;
                end
            end
        end
    end

endmodule

FILE: rtl/eipl_queue.sv
// Short FIFO of captured frames between the capture front end and the decision stage.
`timescale 1ns / 1ps
module eipl_queue #(
    parameter int DEPTH = eipl_pkg::QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_valid,
    output logic                     wr_ready,
    input  eipl_pkg::frame_capture_t wr_data,
    output logic                     rd_valid,
    input  logic                     rd_ready,
    output eipl_pkg::frame_capture_t rd_data
);
    import eipl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    frame_capture_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != CW'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (rd) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + CW'(wr) - CW'(rd);
        end
    end

endmodule

FILE: rtl/eipl_decide.sv
// Back end: decides frame status, masks fields and holds the summary output register.
`timescale 1ns / 1ps
module eipl_decide (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [31:0]              filter_addr,
    input  logic                     cap_valid,
    output logic                     cap_ready,
    input  eipl_pkg::frame_capture_t cap_data,
    output logic                     sum_valid,
    input  logic                     sum_ready,
    output eipl_pkg::frame_summary_t sum_data
);
    import eipl_pkg::*;

    frame_summary_t s;
    logic [2:0] st;
    logic is_l4;

    assign cap_ready = !sum_valid || sum_ready;

    always_comb begin
        is_l4 = cap_data.ip_protocol == PROTO_TCP || cap_data.ip_protocol == PROTO_UDP;
        if (!cap_data.len_ok_eth) begin
            st = ST_TRUNCATED;
        end else if (cap_data.ether_type != IPV4_ETHER_TYPE) begin
            st = ST_NOT_IPV4;
        end else if (!cap_data.len_ok_22) begin
            st = ST_TRUNCATED;
        end else if (cap_data.fragment_offset != '0) begin
            st = ST_FRAGMENTED;
        end else if (!cap_data.len_ok_24) begin
            st = ST_TRUNCATED;
        end else if (!is_l4) begin
            st = ST_NOT_L4;
        end else if (!cap_data.len_ok_30) begin
            st = ST_TRUNCATED;
        end else if (filter_addr != '0 && cap_data.source_ip != filter_addr) begin
            st = ST_FILTERED;
        end else if (!cap_data.len_ok_l4) begin
            st = ST_TRUNCATED;
        end else if (cap_data.ip_protocol == PROTO_TCP) begin
            st = ST_TCP;
        end else begin
            st = ST_UDP;
        end
        s = '0;
        s.status = st;
        s.destination_mac = cap_data.destination_mac;
        s.source_mac = cap_data.source_mac;
        s.ether_type = cap_data.ether_type;
        if (st != ST_NOT_IPV4) begin
            s.ip_total_length = cap_data.ip_total_length;
        end
        if (st >= ST_NOT_L4) begin
            s.time_to_live = cap_data.time_to_live;
            s.ip_protocol = cap_data.ip_protocol;
        end
        if (st >= ST_FILTERED) begin
            s.source_ip = cap_data.source_ip;
            s.destination_ip = cap_data.destination_ip;
        end
        if (st >= ST_TCP) begin
            s.source_port = cap_data.source_port;
            s.destination_port = cap_data.destination_port;
            s.transport_detail = cap_data.transport_detail;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid <= 1'b0;
        end else if (cap_ready) begin
            sum_valid <= cap_valid;
            if (cap_valid) begin
                sum_data <= s;
            end
        end
    end

endmodule

FILE: rtl/eth_ipv4_l4_header_parser.sv
// Top level of the Ethernet/IPv4/TCP-UDP header parser.
//   channel  | direction | handshake          | payload
//   s_       | in        | s_valid / s_ready  | frame_byte, last_byte
//   m_       | out       | m_valid / m_ready  | one summary per frame
//   cfg      | in        | cfg_we             | source address filter
// One beat per cycle while s_ready is high; s_ready follows the queue's free space.
// A summary passes the frame register, the queue and the output register after the last beat.
// Synchronous active-low reset clears capture state, valid flags, queue pointers and the filter.
// Input stalls whenever the queue is full.
`timescale 1ns / 1ps
module eth_ipv4_l4_header_parser #(
    parameter int MAX_FRAME_BYTES = eipl_pkg::MAX_FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH = eipl_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [47:0] m_destination_mac,
    output logic [47:0] m_source_mac,
    output logic [15:0] m_ether_type,
    output logic [15:0] m_ip_total_length,
    output logic [7:0]  m_time_to_live,
    output logic [7:0]  m_ip_protocol,
    output logic [31:0] m_source_ip,
    output logic [31:0] m_destination_ip,
    output logic [15:0] m_source_port,
    output logic [15:0] m_destination_port,
    output logic [15:0] m_transport_detail
);
    import eipl_pkg::*;

    logic [31:0] filter_reg;
    logic c_valid, c_ready, q_valid, q_ready;
    frame_capture_t c_data, q_data;
    frame_summary_t sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= '0;
        end else if (cfg_we) begin
            filter_reg <= cfg_wdata;
        end
    end

    eipl_capture #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_capture (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_byte(s_frame_byte), .in_last(s_last_byte),
        .cap_valid(c_valid), .cap_ready(c_ready), .cap_data(c_data)
    );

    eipl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(c_valid), .wr_ready(c_ready), .wr_data(c_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    eipl_decide u_decide (
        .aclk(aclk), .aresetn(aresetn), .filter_addr(filter_reg),
        .cap_valid(q_valid), .cap_ready(q_ready), .cap_data(q_data),
        .sum_valid(m_valid), .sum_ready(m_ready), .sum_data(sum)
    );

    assign m_status = sum.status;
    assign m_destination_mac = sum.destination_mac;
    assign m_source_mac = sum.source_mac;
    assign m_ether_type = sum.ether_type;
    assign m_ip_total_length = sum.ip_total_length;
    assign m_time_to_live = sum.time_to_live;
    assign m_ip_protocol = sum.ip_protocol;
    assign m_source_ip = sum.source_ip;
    assign m_destination_ip = sum.destination_ip;
    assign m_source_port = sum.source_port;
    assign m_destination_port = sum.destination_port;
    assign m_transport_detail = sum.transport_detail;

endmodule
